// ----- sv/u8u16_pkg.sv -----
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam logic [15:0] ReplChar   = 16'hFFFD;
  localparam logic [15:0] HiSurBase  = 16'hD800;
  localparam logic [15:0] LoSurBase  = 16'hDC00;
  localparam logic [15:0] SurFirst   = 16'hD800;
  localparam logic [15:0] SurLast    = 16'hDFFF;
  localparam logic [10:0] Min2Byte   = 11'h080;
  localparam logic [15:0] Min3Byte   = 16'h0800;
  localparam logic [20:0] Min4Byte   = 21'h010000;
  localparam logic [20:0] MaxCodePt  = 21'h10FFFF;

  // Units caused by one byte: nrep replacement units first, then up to two
  // genuine units (a BMP unit or a surrogate pair).
  typedef struct packed {
    logic [2:0]  nrep;
    logic [1:0]  ntail;
    logic [15:0] tail0;
    logic [15:0] tail1;
    logic        eos;
  } burst_t;

  // Continuation bytes a lead needs; 0 when the byte is no multi-byte lead.
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b[7:5] == 3'b110) begin
      n = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      n = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

// ----- sv/utf8_to_utf16_stream_core.sv -----
`timescale 1ns / 1ps

// UTF-8 to UTF-16 stream transcoder. One byte is accepted per cycle into an
// input register while in_stall_o is low and decoded in the following cycle;
// the code units it causes (zero to four) are loaded into the output stage
// when the byte leaves the input register, and are then presented one unit
// per cycle while out_stall_i is low. A byte that causes several units holds
// the output stage until its last unit transfers, so input transfers stall
// while a burst of replacement units or a surrogate pair drains; bytes that
// only buffer into an open sequence pass without touching the output. Invalid,
// overlong, surrogate, out-of-range or truncated sequences become 0xFFFD
// units with replaced_o set; run_last_o marks the last unit of a byte and
// string_last_o the last unit of a byte that carried end_of_string_i.
module utf8_to_utf16_stream_core import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] unit_o,
  output logic        replaced_o,
  output logic        run_last_o,
  output logic        string_last_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       eos_q;
  logic       adv, load, free, accept, pend_active;
  burst_t     burst;

  assign accept     = in_valid_i && !in_stall_o;
  assign adv        = in_vld_q && (((burst.nrep == 3'd0) && (burst.ntail == 2'd0)) || free);
  assign load       = adv && !((burst.nrep == 3'd0) && (burst.ntail == 2'd0));
  assign in_stall_o = in_vld_q && !adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_in_i;
      eos_q  <= end_of_string_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .byte_i        (byte_q),
    .eos_i         (eos_q),
    .burst_o       (burst),
    .pend_active_o (pend_active)
  );

  u8u16_burst_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .burst_i       (burst),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .unit_o        (unit_o),
    .replaced_o    (replaced_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

`ifndef SYNTHESIS
  // end of string always closes any open sequence
  a_eos_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && eos_q) |=> !pend_active)
    else $error("sequence still open after end of string");

  // a byte with end of string must produce at least one unit
  a_eos_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && eos_q) |-> load)
    else $error("end of string byte produced no unit");

  a_repl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && replaced_o) |-> (unit_o == ReplChar))
    else $error("replaced unit is not 0xFFFD");

  a_string_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_last_o) |-> run_last_o)
    else $error("string_last without run_last");
`endif

endmodule

// ----- sv/u8u16_decode.sv -----
`timescale 1ns / 1ps

module u8u16_decode import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [7:0]  byte_i,
  input  logic        eos_i,
  output burst_t      burst_o,
  output logic        pend_active_o
);

  logic [7:0]  lead_q, lead_d;
  logic        act_q, act_d;
  logic [11:0] pay_q, pay_d;
  logic [1:0]  seen_q, seen_d;

  logic [1:0]  need_lead, need_byte;
  logic        is_cont, complete, fresh_ascii, fresh_open, ok;
  logic [5:0]  c;
  logic [10:0] cp1;
  logic [15:0] cp2;
  logic [20:0] cp3, v;
  burst_t      b_d;

  assign need_lead   = lead_need(lead_q);
  assign need_byte   = lead_need(byte_i);
  assign is_cont     = (byte_i[7:6] == 2'b10);
  assign c           = byte_i[5:0];
  assign complete    = ({1'b0, seen_q} + 3'd1) >= {1'b0, need_lead};
  assign fresh_ascii = !byte_i[7];
  assign fresh_open  = (need_byte != 2'd0) && !eos_i;

  assign cp1 = {lead_q[4:0], c};
  assign cp2 = {lead_q[3:0], pay_q[5:0], c};
  assign cp3 = {lead_q[2:0], pay_q, c};
  assign v   = cp3 - Min4Byte;

  always_comb begin
    case (need_lead)
      2'd1:    ok = (cp1 >= Min2Byte);
      2'd2:    ok = (cp2 >= Min3Byte) && !((cp2 >= SurFirst) && (cp2 <= SurLast));
      default: ok = (cp3 >= Min4Byte) && (cp3 <= MaxCodePt);
    endcase
  end

  always_comb begin
    b_d     = '0;
    b_d.eos = eos_i;
    lead_d  = lead_q;
    act_d   = act_q;
    pay_d   = pay_q;
    seen_d  = seen_q;
    if (!act_q || !is_cont) begin
      if (act_q) begin
        // broken sequence: one replacement for the lead and each buffered byte
        b_d.nrep = {1'b0, seen_q} + 3'd1;
        act_d    = 1'b0;
        lead_d   = '0;
        pay_d    = '0;
        seen_d   = '0;
      end
      if (fresh_ascii) begin
        b_d.ntail = 2'd1;
        b_d.tail0 = {8'h00, byte_i};
      end else if (fresh_open) begin
        lead_d = byte_i;
        act_d  = 1'b1;
        pay_d  = '0;
        seen_d = '0;
      end else begin
        b_d.nrep = b_d.nrep + 3'd1;
      end
    end else if (complete) begin
      if (ok) begin
        case (need_lead)
          2'd1: begin
            b_d.ntail = 2'd1;
            b_d.tail0 = {5'd0, cp1};
          end
          2'd2: begin
            b_d.ntail = 2'd1;
            b_d.tail0 = cp2;
          end
          default: begin
            b_d.ntail = 2'd2;
            b_d.tail0 = HiSurBase + {6'd0, v[19:10]};
            b_d.tail1 = LoSurBase + {6'd0, v[9:0]};
          end
        endcase
      end else begin
        b_d.nrep = {1'b0, seen_q} + 3'd2;
      end
      act_d  = 1'b0;
      lead_d = '0;
      pay_d  = '0;
      seen_d = '0;
    end else if (eos_i) begin
      b_d.nrep = {1'b0, seen_q} + 3'd2;
    end else begin
      pay_d  = {pay_q[5:0], c};
      seen_d = seen_q + 2'd1;
    end
    if (eos_i) begin
      act_d  = 1'b0;
      lead_d = '0;
      pay_d  = '0;
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      act_q  <= 1'b0;
      pay_q  <= '0;
      seen_q <= '0;
    end else if (adv_i) begin
      lead_q <= lead_d;
      act_q  <= act_d;
      pay_q  <= pay_d;
      seen_q <= seen_d;
    end
  end

  assign burst_o       = b_d;
  assign pend_active_o = act_q;

endmodule

// ----- sv/u8u16_burst_out.sv -----
`timescale 1ns / 1ps

module u8u16_burst_out import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  burst_t      burst_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] unit_o,
  output logic        replaced_o,
  output logic        run_last_o,
  output logic        string_last_o
);

  burst_t     burst_q;
  logic       vld_q, vld_d;
  logic [1:0] idx_q, idx_d;
  logic [2:0] total, tail_pos;
  logic       last, xfer;

  assign total    = burst_q.nrep + {1'b0, burst_q.ntail};
  assign last     = ({1'b0, idx_q} == (total - 3'd1));
  assign tail_pos = {1'b0, idx_q} - burst_q.nrep;
  assign xfer     = vld_q && !out_stall_i;
  assign free_o   = !vld_q || (last && !out_stall_i);

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      vld_d = 1'b1;
      idx_d = '0;
    end else if (xfer) begin
      if (last) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign out_valid_o   = vld_q;
  assign replaced_o    = ({1'b0, idx_q} < burst_q.nrep);
  assign unit_o        = replaced_o ? ReplChar :
                         (tail_pos[0] ? burst_q.tail1 : burst_q.tail0);
  assign run_last_o    = last;
  assign string_last_o = last && burst_q.eos;

endmodule

// ----- tb/sv/tb_utf8_to_utf16_stream_core.sv -----
`timescale 1ns / 1ps

module tb_utf8_to_utf16_stream_core;
  import u8u16_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [15:0] code;
    logic        repl;
    logic        run_last;
    logic        str_last;
  } utf16_unit_t;

  typedef enum int {
    CharAscii,
    CharTwo,
    CharThree,
    CharFour,
    CharOverlong,
    CharTooHigh,
    CharStray,
    CharCutOff,
    CharTruncated
  } char_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  byte_in = 8'h00;
  logic        byte_eos = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] unit_out;
  logic        repl_out;
  logic        run_last_out;
  logic        str_last_out;

  utf8_to_utf16_stream_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .byte_in_i      (byte_in),
    .end_of_string_i(byte_eos),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .unit_o         (unit_out),
    .replaced_o     (repl_out),
    .run_last_o     (run_last_out),
    .string_last_o  (str_last_out)
  );

  initial forever #1 clk = ~clk;

  // Decoder state mirrored by the predictor
  logic [7:0]  open_lead;
  logic        seq_open;
  logic [17:0] cont_bits;
  logic [1:0]  cont_seen;

  utf16_unit_t burst [4];
  int          burst_n;
  utf16_unit_t expected_units [$];

  int          bytes_sent = 0;
  int          units_checked = 0;
  int          repl_checked = 0;
  int          pairs_predicted = 0;
  int          errors = 0;
  logic        burst_mode = 1'b0;
  int          stall_hold = 0;
  int          stall_run = 0;
  int          stall_pick;
  int unsigned cycle_cnt = 0;

  function automatic int cont_needed(input logic [7:0] b);
    if (b[7:5] == 3'b110) return 1;
    if (b[7:4] == 4'b1110) return 2;
    if (b[7:3] == 5'b11110) return 3;
    return 0;
  endfunction

  function automatic void add_unit(input logic [15:0] code, input logic repl);
    if (burst_n < 4) begin
      burst[burst_n] = '{code, repl, 1'b0, 1'b0};
      burst_n++;
    end
  endfunction

  function automatic void close_seq();
    open_lead = 8'h00;
    seq_open  = 1'b0;
    cont_bits = '0;
    cont_seen = 2'd0;
  endfunction

  // Lead plus every buffered continuation byte turn into replacements
  function automatic void flush_open();
    add_unit(ReplChar, 1'b1);
    for (int i = 0; i < int'(cont_seen); i++) add_unit(ReplChar, 1'b1);
    close_seq();
  endfunction

  function automatic void take_fresh(input logic [7:0] b, input logic eos);
    if (b < 8'h80) begin
      add_unit({8'h00, b}, 1'b0);
    end else if (cont_needed(b) != 0 && !eos) begin
      open_lead = b;
      seq_open  = 1'b1;
      cont_bits = '0;
      cont_seen = 2'd0;
    end else begin
      add_unit(ReplChar, 1'b1);
    end
  endfunction

  // Works out the units one accepted byte causes and queues them
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    int          need;
    logic [20:0] cp;
    logic        ok;
    logic [19:0] off;
    burst_n = 0;
    if (!seq_open) begin
      take_fresh(b, eos);
    end else if (b[7:6] == 2'b10) begin
      need = cont_needed(open_lead);
      if (int'(cont_seen) + 1 >= need) begin
        if (need == 1) begin
          cp = {10'd0, open_lead[4:0], b[5:0]};
          ok = cp >= Min2Byte;
        end else if (need == 2) begin
          cp = {5'd0, open_lead[3:0], cont_bits[5:0], b[5:0]};
          ok = cp >= Min3Byte && !(cp >= SurFirst && cp <= SurLast);
        end else begin
          cp = {open_lead[2:0], cont_bits[11:0], b[5:0]};
          ok = cp >= Min4Byte && cp <= MaxCodePt;
        end
        if (ok) begin
          if (cp <= 21'h00FFFF) begin
            add_unit(cp[15:0], 1'b0);
          end else begin
            off = 20'(cp - Min4Byte);
            add_unit(HiSurBase + {6'd0, off[19:10]}, 1'b0);
            add_unit(LoSurBase + {6'd0, off[9:0]}, 1'b0);
            pairs_predicted++;
          end
          close_seq();
        end else begin
          flush_open();
          add_unit(ReplChar, 1'b1);
        end
      end else if (eos) begin
        flush_open();
        add_unit(ReplChar, 1'b1);
      end else begin
        cont_bits = {cont_bits[11:0], b[5:0]};
        cont_seen = cont_seen + 2'd1;
      end
    end else begin
      flush_open();
      take_fresh(b, eos);
    end
    if (eos) close_seq();
    if (burst_n > 0) begin
      burst[burst_n - 1].run_last = 1'b1;
      burst[burst_n - 1].str_last = eos;
    end
    for (int i = 0; i < burst_n; i++) expected_units.push_back(burst[i]);
  endfunction

  // Receiver: random stall runs, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold--;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(1, 8);
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else if (stall_pick < 95) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected unit: expected none, got %h", $time, unit_out);
        errors++;
      end else begin
        if (unit_out !== expected_units[0].code) begin
          $display("%0t: unit mismatch: expected %h, got %h", $time,
                   expected_units[0].code, unit_out);
          errors++;
        end
        if (repl_out !== expected_units[0].repl) begin
          $display("%0t: replaced mismatch: expected %b, got %b", $time,
                   expected_units[0].repl, repl_out);
          errors++;
        end
        if (run_last_out !== expected_units[0].run_last) begin
          $display("%0t: run_last mismatch: expected %b, got %b", $time,
                   expected_units[0].run_last, run_last_out);
          errors++;
        end
        if (str_last_out !== expected_units[0].str_last) begin
          $display("%0t: string_last mismatch: expected %b, got %b", $time,
                   expected_units[0].str_last, str_last_out);
          errors++;
        end
        if (expected_units[0].repl) repl_checked++;
        units_checked++;
        void'(expected_units.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d units outstanding", $time, expected_units.size());
      $display("tb_utf8_to_utf16_stream_core NOT OK");
      $finish;
    end
  end

  // One byte transfer, followed by a random gap unless in burst mode
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    int r;
    in_valid <= 1'b1;
    byte_in  <= b;
    byte_eos <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, eos);
    bytes_sent++;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 45) gap = 0;
    else if (r < 80) gap = $urandom_range(1, 3);
    else if (r < 95) gap = $urandom_range(4, 10);
    else gap = $urandom_range(15, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Encodes cp in len bytes (overlong when len is too big), sends the first keep
  task automatic send_cp(input logic [20:0] cp, input int len, input int keep,
                         input logic eos);
    logic [7:0] seq [4];
    case (len)
      1: begin
        seq[0] = {1'b0, cp[6:0]};
      end
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(seq[i], eos && (i == keep - 1));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_valid_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_cp(21'h000080, 2, 2, 1'b0);
    send_cp(21'h00FFFD, 3, 3, 1'b0);  // genuine U+FFFD, not flagged
    send_cp(MaxCodePt, 4, 4, 1'b1);
  endtask

  task automatic test_invalid_bytes();
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_broken_sequences();
    send_byte(8'hE1, 1'b0);
    send_byte(8'h41, 1'b0);           // interrupts, then passes as ASCII
    send_cp(21'h00002F, 2, 2, 1'b0);  // overlong
    send_cp(21'h00D800, 3, 3, 1'b0);  // surrogate code point
    send_cp(21'h110000, 4, 4, 1'b1);  // above range, four replacements
  endtask

  task automatic test_truncated();
    send_byte(8'hC3, 1'b1);
    send_cp(21'h000800, 3, 2, 1'b1);
  endtask

  // Output held off while input keeps coming, so the core backs up
  task automatic test_backpressure();
    stall_hold = 200;
    burst_mode = 1'b1;
    repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'h0A, 1'b1);
    burst_mode = 1'b0;
  endtask

  task automatic test_random_strings(input int nbytes);
    int          start;
    int          nchars;
    int          r;
    int          len;
    int          keep;
    logic [20:0] cp;
    logic        last;
    char_kind_e  kind;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      nchars = $urandom_range(1, 10);
      burst_mode = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < nchars; i++) begin
        last = (i == nchars - 1);
        r = $urandom_range(0, 99);
        if (r < 25) kind = CharAscii;
        else if (r < 43) kind = CharTwo;
        else if (r < 60) kind = CharThree;
        else if (r < 72) kind = CharFour;
        else if (r < 78) kind = CharOverlong;
        else if (r < 83) kind = CharTooHigh;
        else if (r < 89) kind = CharStray;
        else if (r < 95) kind = CharCutOff;
        else kind = CharTruncated;
        case (kind)
          CharAscii: begin
            send_cp(21'($urandom_range(0, 'h7F)), 1, 1, last);
          end
          CharTwo: begin
            send_cp(21'($urandom_range('h80, 'h7FF)), 2, 2, last);
          end
          CharThree: begin
            if ($urandom_range(0, 4) == 0) cp = 21'($urandom_range('hD800, 'hDFFF));
            else cp = 21'($urandom_range('h800, 'hFFFF));
            send_cp(cp, 3, 3, last);
          end
          CharFour: begin
            send_cp(21'($urandom_range('h10000, 'h10FFFF)), 4, 4, last);
          end
          CharOverlong: begin
            len = $urandom_range(2, 4);
            cp = 21'($urandom_range(0, len == 2 ? 'h7F : (len == 3 ? 'h7FF : 'hFFFF)));
            send_cp(cp, len, len, last);
          end
          CharTooHigh: begin
            send_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4, last);
          end
          CharStray: begin
            send_byte(8'($urandom_range('h80, 'hFF)), last);
          end
          CharCutOff: begin
            len = $urandom_range(2, 4);
            keep = $urandom_range(1, len - 1);
            send_cp(21'($urandom_range(0, 'h1FFFFF)), len, keep, 1'b0);
            if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 'h7F)), last);
            else send_byte(8'($urandom_range('hC0, 'hFF)), last);
          end
          default: begin
            // string ends mid-sequence; following bytes start a new string
            len = $urandom_range(2, 4);
            keep = $urandom_range(1, len - 1);
            send_cp(21'($urandom_range(0, 'h1FFFFF)), len, keep, 1'b1);
          end
        endcase
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    close_seq();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_valid_extremes();
    wait_drained();
    test_invalid_bytes();
    wait_drained();
    test_broken_sequences();
    wait_drained();
    test_truncated();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_strings(300);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes (directed, held-off output, random strings); checked %0d units",
             bytes_sent, units_checked);
    $display("  of which %0d replacements and %0d surrogate pairs", repl_checked,
             pairs_predicted);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("tb_utf8_to_utf16_stream_core OK");
    end else begin
      $display("tb_utf8_to_utf16_stream_core NOT OK");
    end
    $finish;
  end

endmodule
